// ===== design/kbt_pkg.sv =====
// ----------------------------------------------------------------------------
// kbt_pkg
// Shared types and constants for the keyed block transposition block.
// ----------------------------------------------------------------------------
package kbt_pkg;

  localparam int MAX_KEY_LEN = 8;
  localparam int IDX_W       = $clog2(MAX_KEY_LEN);
  localparam int CNT_W       = $clog2(MAX_KEY_LEN + 1);
  localparam int KEY_W       = 8 * MAX_KEY_LEN;
  localparam int CFG_IDX_W   = 2;

  localparam logic [7:0] PAD_BYTE = 8'h23;

  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_CHARS    = 2'd2;

  typedef struct packed {
    logic [MAX_KEY_LEN-1:0][7:0] bytes;
    logic [CNT_W-1:0]            fill;
    logic [CNT_W-1:0]            len;
    logic                        decrypt;
  } block_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_chars;
    logic [CNT_W-1:0] len;
    logic             decrypt;
  } key_cfg_t;

endpackage

// ===== design/kbt_front.sv =====
// ----------------------------------------------------------------------------
// kbt_front
// Gathers incoming bytes into a block and hands full or final blocks on.
// ----------------------------------------------------------------------------
module kbt_front
  import kbt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  key_cfg_t cfg,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic [7:0] in_byte,
  input  logic     in_end,
  input  logic     q_full,
  output logic     q_push,
  output block_t   q_data
);

  logic [MAX_KEY_LEN-1:0][7:0] bytes;
  logic [MAX_KEY_LEN-1:0][7:0] bytes_next;
  logic [CNT_W-1:0]            fill_count;
  logic [CNT_W-1:0]            fill_inc;
  logic                        accept;
  logic                        flush;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign fill_inc = fill_count + CNT_W'(1);
  assign flush    = accept && ((fill_inc >= cfg.len) || in_end);

  always_comb begin
    bytes_next = bytes;
    bytes_next[fill_count[IDX_W-1:0]] = in_byte;
  end

  assign q_push          = flush;
  assign q_data.bytes    = bytes_next;
  assign q_data.fill     = (fill_inc < cfg.len) ? fill_inc : cfg.len;
  assign q_data.len      = cfg.len;
  assign q_data.decrypt  = cfg.decrypt;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept) begin
      fill_count <= flush ? '0 : fill_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bytes <= bytes_next;
    end
  end

endmodule

// ===== design/kbt_queue.sv =====
// ----------------------------------------------------------------------------
// kbt_queue
// Two-entry block queue between the gathering and emitting sides.
// ----------------------------------------------------------------------------
module kbt_queue
  import kbt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  block_t push_data,
  input  logic   pop,
  output logic   full,
  output logic   head_valid,
  output block_t head
);

  block_t     entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== design/kbt_back.sv =====
// ----------------------------------------------------------------------------
// kbt_back
// Ranks the key positions and emits the bytes of each queued block.
// ----------------------------------------------------------------------------
module kbt_back
  import kbt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  key_cfg_t   cfg,
  input  logic       head_valid,
  input  block_t     head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic [IDX_W-1:0]       rank      [MAX_KEY_LEN];
  logic [IDX_W-1:0]       order     [MAX_KEY_LEN];
  logic [IDX_W-1:0]       rank_next [MAX_KEY_LEN];
  logic [IDX_W-1:0]       order_next[MAX_KEY_LEN];
  logic [7:0]             sel_byte  [MAX_KEY_LEN];
  logic [MAX_KEY_LEN-1:0] emit_mask;
  logic [MAX_KEY_LEN-1:0] done;
  logic [MAX_KEY_LEN-1:0] remaining;
  logic [MAX_KEY_LEN-1:0] pick;
  logic [IDX_W-1:0]       pick_idx;
  logic                   pick_last;
  logic                   load;

  always_comb begin
    logic [CNT_W-1:0] cnt [MAX_KEY_LEN];
    logic [7:0]       kp;
    logic [7:0]       kq;
    for (int p = 0; p < MAX_KEY_LEN; p++) begin
      cnt[p] = '0;
      kp = cfg.key_chars[8*p +: 8];
      for (int q = 0; q < MAX_KEY_LEN; q++) begin
        kq = cfg.key_chars[8*q +: 8];
        if ((CNT_W'(q) < cfg.len) && ((kq < kp) || ((kq == kp) && (q < p)))) begin
          cnt[p] = cnt[p] + CNT_W'(1);
        end
      end
      rank_next[p] = cnt[p][IDX_W-1:0];
    end
    for (int r = 0; r < MAX_KEY_LEN; r++) begin
      order_next[r] = '0;
      for (int p = 0; p < MAX_KEY_LEN; p++) begin
        if ((CNT_W'(p) < cfg.len) && (cnt[p] == CNT_W'(r))) begin
          order_next[r] = order_next[r] | IDX_W'(p);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rank  <= rank_next;
    order <= order_next;
  end

  always_comb begin
    logic [IDX_W-1:0] src;
    for (int j = 0; j < MAX_KEY_LEN; j++) begin
      src = head.decrypt ? rank[j] : order[j];
      sel_byte[j] = ({1'b0, src} < head.fill) ? head.bytes[src] : PAD_BYTE;
      emit_mask[j] = (CNT_W'(j) < head.len) && (!head.decrypt || (sel_byte[j] != PAD_BYTE));
    end
  end

  assign remaining = head_valid ? (emit_mask & ~done) : '0;

  always_comb begin
    pick_idx = '0;
    for (int j = MAX_KEY_LEN - 1; j >= 0; j--) begin
      if (remaining[j]) begin
        pick_idx = IDX_W'(j);
      end
    end
  end

  assign pick      = MAX_KEY_LEN'(1) << pick_idx;
  assign pick_last = ((remaining & ~pick) == '0);
  assign load      = !out_valid || out_ready;
  assign pop       = head_valid && ((remaining == '0) || (load && pick_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done      <= '0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        done <= '0;
      end else if (head_valid && load) begin
        done <= done | pick;
      end
      if (head_valid && load && (remaining != '0)) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_valid && load && (remaining != '0)) begin
      out_byte <= sel_byte[pick_idx];
      out_last <= pick_last;
    end
  end

endmodule

// ===== design/keyed_block_transposition_top.sv =====
// ----------------------------------------------------------------------------
// keyed_block_transposition_top
// Keyed block transposition cipher over a byte stream.
// ----------------------------------------------------------------------------
// Message bytes enter one per cycle and are gathered into blocks of the key
// length; a block is closed when it is full or when tlast marks the final
// byte. Closed blocks wait in a two-entry queue, and the emitting side sends
// one result per cycle, unless the output is stalled, from the block at its
// head: L results for an encrypted block of length L, and only the kept
// bytes for a decrypted block (a decrypted block of padding only gives no
// transfer). The input is stalled only while both queue entries are taken.
// The key ranking is recomputed in a register stage from the configuration
// registers, so it is ready by the first byte after a write.
module keyed_block_transposition_top
  import kbt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] data_byte
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [7:0] out_byte
  output logic                 m_axis_tlast
);

  logic             decrypt_mode;
  logic [3:0]       key_length;
  logic [KEY_W-1:0] key_chars;
  key_cfg_t         cfg;
  logic             q_full;
  logic             q_push;
  block_t           q_data;
  logic             q_pop;
  logic             q_head_valid;
  block_t           q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_mode <= 1'b0;
      key_length   <= 4'd1;
      key_chars    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DECRYPT_MODE: decrypt_mode <= cfg_data[0];
        CFG_KEY_LENGTH:   key_length   <= cfg_data[3:0];
        CFG_KEY_CHARS:    key_chars    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.key_chars = key_chars;
  assign cfg.decrypt   = decrypt_mode;
  assign cfg.len       = (key_length == 4'd0) ? CNT_W'(1) :
                         (key_length > 4'(MAX_KEY_LEN)) ? CNT_W'(MAX_KEY_LEN) :
                         CNT_W'(key_length);

  kbt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_byte  (s_axis_tdata),
    .in_end   (s_axis_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_data)
  );

  kbt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_data),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  kbt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_byte   (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

endmodule
